// ===== design/trdt_pkg.sv =====
// ----------------------------------------------------------------------------
// trdt_pkg
// Shared types and constants of the triangle raster, depth and texture block.
// ----------------------------------------------------------------------------
package trdt_pkg;

    localparam int DEF_SCREEN_W = 800;
    localparam int DEF_SCREEN_H = 600;
    localparam int DEF_TEX_W    = 64;
    localparam int DEF_TEX_H    = 64;

    localparam int TEX_ENTRIES  = 4096;
    localparam int TEX_AW       = 12;
    localparam int COLOR_W      = 32;
    localparam int DEPTH_W      = 16;
    localparam int COORD_W      = 10;
    localparam int VERT_W       = 12;
    localparam int PIDX_W       = 24;
    localparam int PIDX_OUT_W   = 19;
    localparam int TEXC_W       = 8;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 48;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 16'hFFFF;

    // Division by three of an 18-bit depth sum as a reciprocal multiply.
    localparam int DIV3_SHIFT = 19;
    localparam logic [17:0] DIV3_MULT = 18'((2**DIV3_SHIFT + 2) / 3);

    // Shift used for the texture wrap reciprocals.
    localparam int WRAP_SHIFT = 20;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        OP_RASTER      = 2'd0,
        OP_TEXEL       = 2'd1,
        OP_DEPTH_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_V0_X   = 3'd0,
        CFG_V0_Y   = 3'd1,
        CFG_V1_X   = 3'd2,
        CFG_V1_Y   = 3'd3,
        CFG_V2_X   = 3'd4,
        CFG_V2_Y   = 3'd5,
        CFG_DEPTHS = 3'd6
    } t_cfg_idx;

endpackage

// ===== design/trdt_ram.sv =====
// ----------------------------------------------------------------------------
// trdt_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module trdt_ram
    import trdt_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/triangle_raster_depth_texture.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_depth_texture
// Edge-function rasterizer with flat depth test and wrapped texture lookup.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while s_axis_tready is high, set by the
// single read-modify-write of the depth RAM per request; results queue in an
// 8-entry output buffer, and tready drops once eight requests are in flight.
// Reset is synchronous and active low. After reset the depth RAM is swept
// to far, one entry a cycle, over all SCREEN_W*SCREEN_H entries (480000 by
// default) while s_axis_tready stays low; the texture RAM is not cleared.
module triangle_raster_depth_texture
    import trdt_pkg::*;
#(
    parameter int SCREEN_W = DEF_SCREEN_W,
    parameter int SCREEN_H = DEF_SCREEN_H,
    parameter int TEX_W    = DEF_TEX_W,
    parameter int TEX_H    = DEF_TEX_H
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pixel_x, pixel_y, texel_index, texel_color
    input  logic [63:0]       s_axis_tdata,
    // operation
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pixel_index, pixel_color, pixel_depth, zero fill
    output logic [71:0]       m_axis_tdata,
    // pixel_write
    output logic [0:0]        m_axis_tuser
);

    localparam int DEPTH_N = SCREEN_W * SCREEN_H;
    localparam int DA      = $clog2(DEPTH_N);
    localparam logic [DA-1:0] CLR_LAST = DA'(DEPTH_N - 1);
    localparam logic [30:0] MX = 31'((2**WRAP_SHIFT + TEX_W - 1) / TEX_W);
    localparam logic [30:0] MY = 31'((2**WRAP_SHIFT + TEX_H - 1) / TEX_H);
    localparam int RES_W = PIDX_OUT_W + COLOR_W + DEPTH_W;
    localparam int EA [3] = '{1, 2, 0};
    localparam int EB [3] = '{2, 0, 1};

    // Configuration registers.
    logic signed [VERT_W-1:0] r_vx [3];
    logic signed [VERT_W-1:0] r_vy [3];
    logic [CFG_DW-1:0]        r_vdepths;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < 3; v++) begin
                r_vx[v] <= '0;
                r_vy[v] <= '0;
            end
            r_vdepths <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_V0_X:   r_vx[0]   <= i_cfg_data[VERT_W-1:0];
                CFG_V0_Y:   r_vy[0]   <= i_cfg_data[VERT_W-1:0];
                CFG_V1_X:   r_vx[1]   <= i_cfg_data[VERT_W-1:0];
                CFG_V1_Y:   r_vy[1]   <= i_cfg_data[VERT_W-1:0];
                CFG_V2_X:   r_vx[2]   <= i_cfg_data[VERT_W-1:0];
                CFG_V2_Y:   r_vy[2]   <= i_cfg_data[VERT_W-1:0];
                CFG_DEPTHS: r_vdepths <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Depth clearing sweep and flow control.
    logic                 r_clearing;
    logic [DA-1:0]        r_clr_addr;
    logic [FIFO_AW:0]     r_credit;
    logic [FIFO_AW:0]     r_fifo_cnt;
    logic                 w_in_acc;
    logic                 w_out_acc;

    assign s_axis_tready = !r_clearing && (r_credit < (FIFO_AW+1)'(FIFO_DEPTH));
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + (FIFO_AW+1)'(w_in_acc) - (FIFO_AW+1)'(w_out_acc);
        end
    end

    // Stage 1: captured request.
    logic               r_p1_valid;
    t_op                r_p1_op;
    logic [COORD_W-1:0] r_p1_x;
    logic [COORD_W-1:0] r_p1_y;
    logic [TEX_AW-1:0]  r_p1_tidx;
    logic [COLOR_W-1:0] r_p1_tcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_in_acc;
        end
        r_p1_op   <= t_op'(s_axis_tuser);
        r_p1_x    <= s_axis_tdata[9:0];
        r_p1_y    <= s_axis_tdata[19:10];
        r_p1_tidx <= s_axis_tdata[31:20];
        r_p1_tcol <= s_axis_tdata[63:32];
    end

    // Stage 2: edge differences, depth sum, wrap quotients, pixel index.
    logic                  r_p2_valid;
    t_op                   r_p2_op;
    logic                  r_p2_on;
    logic [COORD_W-1:0]    r_p2_x;
    logic [COORD_W-1:0]    r_p2_y;
    logic [TEX_AW-1:0]     r_p2_tidx;
    logic [COLOR_W-1:0]    r_p2_tcol;
    logic signed [12:0]    r_p2_dpx [3];
    logic signed [12:0]    r_p2_dby [3];
    logic signed [12:0]    r_p2_dpy [3];
    logic signed [12:0]    r_p2_dbx [3];
    logic [17:0]           r_p2_sum;
    logic [COORD_W-1:0]    r_p2_qx;
    logic [COORD_W-1:0]    r_p2_qy;
    logic [PIDX_W-1:0]     r_p2_pidx;
    logic signed [12:0]    w_px;
    logic signed [12:0]    w_py;
    logic [30:0]           w_qx_prod;
    logic [30:0]           w_qy_prod;

    assign w_px = $signed({3'b000, r_p1_x});
    assign w_py = $signed({3'b000, r_p1_y});
    assign w_qx_prod = {21'b0, r_p1_x} * MX;
    assign w_qy_prod = {21'b0, r_p1_y} * MY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
        r_p2_op   <= r_p1_op;
        r_p2_on   <= ({3'b000, r_p1_x} < 13'(SCREEN_W)) &&
                     ({3'b000, r_p1_y} < 13'(SCREEN_H));
        r_p2_x    <= r_p1_x;
        r_p2_y    <= r_p1_y;
        r_p2_tidx <= r_p1_tidx;
        r_p2_tcol <= r_p1_tcol;
        for (int e = 0; e < 3; e++) begin
            r_p2_dpx[e] <= w_px - 13'(r_vx[EA[e]]);
            r_p2_dpy[e] <= w_py - 13'(r_vy[EA[e]]);
            r_p2_dby[e] <= 13'(r_vy[EB[e]]) - 13'(r_vy[EA[e]]);
            r_p2_dbx[e] <= 13'(r_vx[EB[e]]) - 13'(r_vx[EA[e]]);
        end
        r_p2_sum  <= {2'b00, r_vdepths[15:0]} + {2'b00, r_vdepths[31:16]}
                   + {2'b00, r_vdepths[47:32]};
        r_p2_qx   <= w_qx_prod[WRAP_SHIFT +: COORD_W];
        r_p2_qy   <= w_qy_prod[WRAP_SHIFT +: COORD_W];
        r_p2_pidx <= {14'b0, r_p1_y} * PIDX_W'(SCREEN_W) + {14'b0, r_p1_x};
    end

    // Stage 3: edge products, flat depth, texture coordinates.
    logic                  r_p3_valid;
    t_op                   r_p3_op;
    logic                  r_p3_on;
    logic [TEX_AW-1:0]     r_p3_tidx;
    logic [COLOR_W-1:0]    r_p3_tcol;
    logic [PIDX_W-1:0]     r_p3_pidx;
    logic signed [25:0]    r_p3_pa [3];
    logic signed [25:0]    r_p3_pb [3];
    logic [DEPTH_W-1:0]    r_p3_z;
    logic [TEXC_W-1:0]     r_p3_tx;
    logic [TEXC_W-1:0]     r_p3_ty;
    logic [35:0]           w_z_prod;
    logic [18:0]           w_tx_full;
    logic [18:0]           w_ty_full;

    assign w_z_prod  = {18'b0, r_p2_sum} * {18'b0, DIV3_MULT};
    assign w_tx_full = {9'b0, r_p2_x} - {9'b0, r_p2_qx} * 19'(TEX_W);
    assign w_ty_full = {9'b0, r_p2_y} - {9'b0, r_p2_qy} * 19'(TEX_H);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else begin
            r_p3_valid <= r_p2_valid;
        end
        r_p3_op   <= r_p2_op;
        r_p3_on   <= r_p2_on;
        r_p3_tidx <= r_p2_tidx;
        r_p3_tcol <= r_p2_tcol;
        r_p3_pidx <= r_p2_pidx;
        for (int e = 0; e < 3; e++) begin
            r_p3_pa[e] <= 26'(r_p2_dpx[e]) * 26'(r_p2_dby[e]);
            r_p3_pb[e] <= 26'(r_p2_dpy[e]) * 26'(r_p2_dbx[e]);
        end
        r_p3_z  <= w_z_prod[DIV3_SHIFT +: DEPTH_W];
        r_p3_tx <= w_tx_full[TEXC_W-1:0];
        r_p3_ty <= w_ty_full[TEXC_W-1:0];
    end

    // Stage 4: inside test and texel address; RAM reads and texel writes issue here.
    logic                  r_p4_valid;
    t_op                   r_p4_op;
    logic                  r_p4_on;
    logic [TEX_AW-1:0]     r_p4_tidx;
    logic [COLOR_W-1:0]    r_p4_tcol;
    logic [PIDX_W-1:0]     r_p4_pidx;
    logic                  r_p4_inside;
    logic [DEPTH_W-1:0]    r_p4_z;
    logic [TEX_AW-1:0]     r_p4_taddr;
    logic signed [26:0]    w_w [3];
    logic [16:0]           w_taddr_full;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            w_w[e] = 27'(r_p3_pa[e]) - 27'(r_p3_pb[e]);
        end
    end

    assign w_taddr_full = {9'b0, r_p3_ty} * 17'(TEX_W) + {9'b0, r_p3_tx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else begin
            r_p4_valid <= r_p3_valid;
        end
        r_p4_op     <= r_p3_op;
        r_p4_on     <= r_p3_on;
        r_p4_tidx   <= r_p3_tidx;
        r_p4_tcol   <= r_p3_tcol;
        r_p4_pidx   <= r_p3_pidx;
        r_p4_inside <= !w_w[0][26] && !w_w[1][26] && !w_w[2][26];
        r_p4_z      <= r_p3_z;
        r_p4_taddr  <= w_taddr_full[TEX_AW-1:0];
    end

    logic                 w_tex_we;
    logic                 w_tex_re;
    logic [COLOR_W-1:0]   w_tex_rdata;
    logic                 w_dram_we;
    logic [DA-1:0]        w_dram_waddr;
    logic [DEPTH_W-1:0]   w_dram_wdata;
    logic [DEPTH_W-1:0]   w_dram_rdata;

    assign w_tex_we = r_p4_valid && (r_p4_op == OP_TEXEL);
    assign w_tex_re = r_p4_valid && (r_p4_op == OP_RASTER);

    trdt_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TEX_ENTRIES)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (w_tex_we),
        .i_waddr (r_p4_tidx),
        .i_wdata (r_p4_tcol),
        .i_re    (w_tex_re),
        .i_raddr (r_p4_taddr),
        .o_rdata (w_tex_rdata)
    );

    trdt_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (DEPTH_N)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (w_dram_we),
        .i_waddr (w_dram_waddr),
        .i_wdata (w_dram_wdata),
        .i_re    (r_p4_valid),
        .i_raddr (r_p4_pidx[DA-1:0]),
        .o_rdata (w_dram_rdata)
    );

    // Stage 5: depth compare and write-back, result into the output buffer.
    logic                  r_p5_valid;
    t_op                   r_p5_op;
    logic                  r_p5_on;
    logic [PIDX_W-1:0]     r_p5_pidx;
    logic                  r_p5_inside;
    logic [DEPTH_W-1:0]    r_p5_z;
    logic                  r_fwd_valid;
    logic [DA-1:0]         r_fwd_addr;
    logic [DEPTH_W-1:0]    r_fwd_data;
    logic [DEPTH_W-1:0]    w_cur_depth;
    logic                  w_pass;
    logic                  w_dclear;
    logic                  w_item_we;
    logic [DEPTH_W-1:0]    w_item_wdata;
    logic [RES_W-1:0]      w_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else begin
            r_p5_valid <= r_p4_valid;
        end
        r_p5_op     <= r_p4_op;
        r_p5_on     <= r_p4_on;
        r_p5_pidx   <= r_p4_pidx;
        r_p5_inside <= r_p4_inside;
        r_p5_z      <= r_p4_z;
    end

    // The request in the stage ahead wrote while this one was reading.
    assign w_cur_depth = (r_fwd_valid && (r_fwd_addr == r_p5_pidx[DA-1:0])) ?
                         r_fwd_data : w_dram_rdata;
    assign w_pass   = (r_p5_op == OP_RASTER) && r_p5_on && r_p5_inside &&
                      (r_p5_z < w_cur_depth);
    assign w_dclear = (r_p5_op == OP_DEPTH_CLEAR) && r_p5_on;
    assign w_item_we    = r_p5_valid && (w_pass || w_dclear);
    assign w_item_wdata = w_pass ? r_p5_z : DEPTH_FAR;

    assign w_dram_we    = r_clearing || w_item_we;
    assign w_dram_waddr = r_clearing ? r_clr_addr : r_p5_pidx[DA-1:0];
    assign w_dram_wdata = r_clearing ? DEPTH_FAR : w_item_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_item_we;
        end
        r_fwd_addr <= r_p5_pidx[DA-1:0];
        r_fwd_data <= w_item_wdata;
    end

    assign w_res_data = w_pass ?
                        {r_p5_z, w_tex_rdata, r_p5_pidx[PIDX_OUT_W-1:0]} : '0;

    // Output buffer.
    logic [RES_W-1:0]   r_fifo_data [FIFO_DEPTH];
    logic               r_fifo_user [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_p5_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt + (FIFO_AW+1)'(r_p5_valid)
                        - (FIFO_AW+1)'(w_out_acc);
        end
        if (r_p5_valid) begin
            r_fifo_data[r_wr_ptr] <= w_res_data;
            r_fifo_user[r_wr_ptr] <= w_pass;
        end
    end

    assign m_axis_tvalid   = (r_fifo_cnt != '0);
    assign m_axis_tdata    = {5'b00000, r_fifo_data[r_rd_ptr]};
    assign m_axis_tuser[0] = r_fifo_user[r_rd_ptr];

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("request credit exceeds output buffer depth");

    a_fifo_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_credit)
        else $error("buffered results exceed outstanding requests");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p5_valid |-> (r_fifo_cnt < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result pushed into a full output buffer");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("request accepted during depth clear");

    a_write_not_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[66:51] != DEPTH_FAR))
        else $error("pixel write carries far depth");

endmodule

// ===== tb/triangle_raster_depth_texture_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_raster_depth_texture_tb
// Self-checking bench for the triangle raster, depth and texture block. It
// sends directed and random pixel, texel and depth-clear requests across a
// series of triangles and vertex depths. Each accepted request is mirrored
// in a behavioral copy of the depth and texture stores. Every result is
// compared field by field, in order, with the predicted framebuffer write.
// ----------------------------------------------------------------------------
module triangle_raster_depth_texture_tb;
    import trdt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SCREEN_PIXELS = DEF_SCREEN_W * DEF_SCREEN_H;
    localparam int COORD_MAX     = 2**COORD_W - 1;
    localparam int ITEM_TARGET   = 550;
    localparam int QUIET_TAIL    = 80;
    localparam int POOL_SIZE     = 24;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                  write;
        logic [PIDX_OUT_W-1:0] index;
        logic [COLOR_W-1:0]    color;
        logic [DEPTH_W-1:0]    depth;
    } pixel_write_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;
    logic [1:0]        s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [71:0]       m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    bit idle_on = 1'b0;
    int stall_left = 0;
    int requests_sent = 0;
    bit texel_loaded [TEX_ENTRIES];
    int vx_now [3];
    int vy_now [3];
    int pool_x [POOL_SIZE];
    int pool_y [POOL_SIZE];

    triangle_raster_depth_texture u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic int texel_addr(int x, int y);
        return ((y % DEF_TEX_H) * DEF_TEX_W + x % DEF_TEX_W) % TEX_ENTRIES;
    endfunction

    class pixel_writes;
        logic signed [VERT_W-1:0] vert_x [3];
        logic signed [VERT_W-1:0] vert_y [3];
        logic [CFG_DW-1:0]        vert_depths;
        logic [DEPTH_W-1:0]       depth_mem [SCREEN_PIXELS];
        logic [COLOR_W-1:0]       texels [TEX_ENTRIES];
        pixel_write_t             expected_writes [$];
        int                       mismatch_count;

        function new();
            foreach (depth_mem[i]) depth_mem[i] = DEPTH_FAR;
            foreach (vert_x[i]) begin
                vert_x[i] = '0;
                vert_y[i] = '0;
            end
            vert_depths = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_V0_X:   vert_x[0] = data[VERT_W-1:0];
                CFG_V0_Y:   vert_y[0] = data[VERT_W-1:0];
                CFG_V1_X:   vert_x[1] = data[VERT_W-1:0];
                CFG_V1_Y:   vert_y[1] = data[VERT_W-1:0];
                CFG_V2_X:   vert_x[2] = data[VERT_W-1:0];
                CFG_V2_Y:   vert_y[2] = data[VERT_W-1:0];
                CFG_DEPTHS: vert_depths = data;
                default: ;
            endcase
        endfunction

        function longint edge_fn(int a, int b, int px, int py);
            return (longint'(px) - vert_x[a]) * (longint'(vert_y[b]) - vert_y[a])
                 - (longint'(py) - vert_y[a]) * (longint'(vert_x[b]) - vert_x[a]);
        endfunction

        function void note_request(logic [1:0] op, int x, int y, int tidx,
                                   logic [COLOR_W-1:0] tcol);
            pixel_write_t res;
            int pix;
            int sum;
            int z;
            bit on_screen;
            res = '0;
            pix = y * DEF_SCREEN_W + x;
            on_screen = x < DEF_SCREEN_W && y < DEF_SCREEN_H;
            if (op == OP_TEXEL) begin
                texels[tidx % TEX_ENTRIES] = tcol;
            end else if (op == OP_DEPTH_CLEAR) begin
                if (on_screen) depth_mem[pix] = DEPTH_FAR;
            end else if (op == OP_RASTER && on_screen) begin
                if (edge_fn(1, 2, x, y) >= 0 && edge_fn(2, 0, x, y) >= 0
                        && edge_fn(0, 1, x, y) >= 0) begin
                    sum = vert_depths[15:0] + vert_depths[31:16] + vert_depths[47:32];
                    z = sum / 3;
                    if (z < depth_mem[pix]) begin
                        depth_mem[pix] = DEPTH_W'(z);
                        res.write = 1'b1;
                        res.index = PIDX_OUT_W'(pix);
                        res.color = texels[texel_addr(x, y)];
                        res.depth = DEPTH_W'(z);
                    end
                end
            end
            expected_writes.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_write(logic write, logic [PIDX_OUT_W-1:0] index,
                         logic [COLOR_W-1:0] color, logic [DEPTH_W-1:0] depth);
            pixel_write_t want;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, write=%0b index=%0d",
                                          write, index));
                return;
            end
            want = expected_writes.pop_front();
            if (write !== want.write)
                report_mismatch($sformatf("pixel_write %0b, expected %0b", write, want.write));
            if (index !== want.index)
                report_mismatch($sformatf("pixel_index %0d, expected %0d", index, want.index));
            if (color !== want.color)
                report_mismatch($sformatf("pixel_color %h, expected %h", color, want.color));
            if (depth !== want.depth)
                report_mismatch($sformatf("pixel_depth %0d, expected %0d", depth, want.depth));
        endtask
    endclass

    pixel_writes book = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            book.check_write(m_axis_tuser[0], m_axis_tdata[PIDX_OUT_W-1:0],
                             m_axis_tdata[PIDX_OUT_W +: COLOR_W],
                             m_axis_tdata[PIDX_OUT_W + COLOR_W +: DEPTH_W]);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(logic [1:0] op, int x, int y, int tidx,
                                logic [COLOR_W-1:0] tcol);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {tcol, TEX_AW'(tidx), COORD_W'(y), COORD_W'(x)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book.note_request(op, x, y, tidx, tcol);
        requests_sent++;
    endtask

    task automatic write_texel(int tidx, logic [COLOR_W-1:0] tcol);
        send_request(OP_TEXEL, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     tidx, tcol);
        texel_loaded[tidx] = 1'b1;
    endtask

    // A pixel request may look up its texel, so that texel is loaded first.
    task automatic pixel_request(logic [1:0] op, int x, int y);
        if (!texel_loaded[texel_addr(x, y)]) write_texel(texel_addr(x, y), $urandom);
        send_request(op, x, y, $urandom_range(0, TEX_ENTRIES - 1), $urandom);
    endtask

    task automatic clear_pixel(int x, int y);
        send_request(OP_DEPTH_CLEAR, x, y, $urandom_range(0, TEX_ENTRIES - 1), $urandom);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DW-1:0] vertex_word(int v);
        return {4'($urandom), 32'($urandom), VERT_W'(v)};
    endfunction

    task automatic load_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                 logic [CFG_DW-1:0] zs, bit front);
        longint area;
        int t;
        t_cfg_idx regs [7];
        logic [CFG_DW-1:0] vals [7];
        area = longint'(cx - ax) * (by - ay) - longint'(cy - ay) * (bx - ax);
        if ((front && area < 0) || (!front && area > 0)) begin
            t = bx; bx = cx; cx = t;
            t = by; by = cy; cy = t;
        end
        regs = '{CFG_V0_X, CFG_V0_Y, CFG_V1_X, CFG_V1_Y, CFG_V2_X, CFG_V2_Y, CFG_DEPTHS};
        vals = '{vertex_word(ax), vertex_word(ay), vertex_word(bx), vertex_word(by),
                 vertex_word(cx), vertex_word(cy), zs};
        foreach (regs[r]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= regs[r];
            i_cfg_data <= vals[r];
            book.set_register(regs[r], vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        vx_now = '{ax, bx, cx};
        vy_now = '{ay, by, cy};
    endtask

    function automatic logic [DEPTH_W-1:0] depth_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DEPTH_FAR;
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic void bbox_pixel(output int x, output int y);
        int lo_x, hi_x, lo_y, hi_y;
        lo_x = vx_now[0]; hi_x = lo_x;
        lo_y = vy_now[0]; hi_y = lo_y;
        for (int v = 1; v < 3; v++) begin
            if (vx_now[v] < lo_x) lo_x = vx_now[v];
            if (vx_now[v] > hi_x) hi_x = vx_now[v];
            if (vy_now[v] < lo_y) lo_y = vy_now[v];
            if (vy_now[v] > hi_y) hi_y = vy_now[v];
        end
        if (lo_x < 0) lo_x = 0;
        if (lo_y < 0) lo_y = 0;
        if (hi_x > COORD_MAX) hi_x = COORD_MAX;
        if (hi_y > COORD_MAX) hi_y = COORD_MAX;
        if (lo_x > hi_x || lo_y > hi_y) begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end else begin
            x = $urandom_range(lo_x, hi_x);
            y = $urandom_range(lo_y, hi_y);
        end
    endfunction

    function automatic void pick_pixel(output int x, output int y);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom_range(0, POOL_SIZE - 1);
                x = pool_x[v];
                y = pool_y[v];
            end
            8: begin
                v = $urandom_range(0, 2);
                x = vx_now[v];
                y = vy_now[v];
            end
            9: begin
                x = $urandom_range(0, COORD_MAX);
                y = $urandom_range(0, COORD_MAX);
            end
            default: bbox_pixel(x, y);
        endcase
        if (x < 0 || x > COORD_MAX || y < 0 || y > COORD_MAX) begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end
    endfunction

    initial begin
        int x, y, k, v, kind, dx, dy;
        int ax, ay, bx, by, cx, cy;
        bit front;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A triangle with all vertices at the origin covers every pixel.
        idle_on = 1'b1;
        load_triangle(0, 0, 0, 0, 0, 0, '0, 1'b1);
        write_texel(0, '0);
        write_texel(TEX_ENTRIES - 1, '1);
        pixel_request(OP_RASTER, 0, 0);
        pixel_request(OP_RASTER, 0, 0);
        clear_pixel(0, 0);
        pixel_request(OP_RASTER, 0, 0);
        pixel_request(OP_RASTER, 63, 63);
        pixel_request(OP_RASTER, DEF_SCREEN_W - 1, DEF_SCREEN_H - 1);
        pixel_request(OP_RASTER, DEF_SCREEN_W, 0);
        pixel_request(OP_RASTER, 0, DEF_SCREEN_H);
        pixel_request(OP_RASTER, COORD_MAX, COORD_MAX);
        clear_pixel(COORD_MAX, COORD_MAX);
        clear_pixel(DEF_SCREEN_W - 1, DEF_SCREEN_H - 1);
        pixel_request(OP_RASTER, DEF_SCREEN_W - 1, DEF_SCREEN_H - 1);
        pixel_request(OP_UNUSED, COORD_MAX, COORD_MAX);
        drain();

        // Far depth never passes; one step below far does.
        load_triangle(-2048, 2047, 2047, 2047, 2047, -2048, '1, 1'b1);
        pixel_request(OP_RASTER, 5, 5);
        drain();
        load_triangle(-2048, 2047, 2047, 2047, 2047, -2048, {DEPTH_FAR, DEPTH_FAR,
                      DEPTH_FAR - 16'd1}, 1'b1);
        pixel_request(OP_RASTER, 5, 5);
        pixel_request(OP_RASTER, 0, 0);
        drain();
        load_triangle(-2048, 2047, 2047, 2047, 2047, -2048, '0, 1'b0);
        pixel_request(OP_RASTER, 6, 6);
        drain();

        foreach (pool_x[i]) begin
            pool_x[i] = $urandom_range(0, COORD_MAX);
            pool_y[i] = $urandom_range(0, COORD_MAX);
        end

        while (requests_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 4);
            ax = $urandom_range(0, DEF_SCREEN_W - 1);
            ay = $urandom_range(0, DEF_SCREEN_H - 1);
            front = 1'b1;
            case (kind)
                0, 3: begin
                    bx = ax + int'($urandom_range(0, 80)) - 40;
                    by = ay + int'($urandom_range(0, 80)) - 40;
                    cx = ax + int'($urandom_range(0, 80)) - 40;
                    cy = ay + int'($urandom_range(0, 80)) - 40;
                    front = kind == 0;
                end
                1: begin
                    ax = int'($urandom_range(0, 1000)) - 100;
                    bx = int'($urandom_range(0, 1000)) - 100;
                    cx = int'($urandom_range(0, 1000)) - 100;
                    by = int'($urandom_range(0, 800)) - 100;
                    cy = int'($urandom_range(0, 800)) - 100;
                end
                2: begin
                    ax = int'($urandom_range(0, 4095)) - 2048;
                    ay = int'($urandom_range(0, 4095)) - 2048;
                    bx = int'($urandom_range(0, 4095)) - 2048;
                    by = int'($urandom_range(0, 4095)) - 2048;
                    cx = int'($urandom_range(0, 4095)) - 2048;
                    cy = int'($urandom_range(0, 4095)) - 2048;
                    front = $urandom_range(0, 1);
                end
                default: begin
                    dx = int'($urandom_range(0, 40)) - 20;
                    dy = int'($urandom_range(0, 40)) - 20;
                    bx = ax + dx; by = ay + dy;
                    cx = ax + 2 * dx; cy = ay + 2 * dy;
                end
            endcase
            load_triangle(ax, ay, bx, by, cx, cy,
                          {depth_sample(), depth_sample(), depth_sample()}, front);
            for (k = 0; k < 8; k++) begin
                v = $urandom_range(0, POOL_SIZE - 1);
                bbox_pixel(pool_x[v], pool_y[v]);
            end
            idle_on = $urandom_range(0, 3) != 0;

            for (k = 0; k < 70 && requests_sent < ITEM_TARGET; k++) begin
                if (requests_sent >= ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
                case ($urandom_range(0, 19))
                    12, 13: write_texel($urandom_range(0, TEX_ENTRIES - 1), $urandom);
                    14: begin
                        v = $urandom_range(0, POOL_SIZE - 1);
                        write_texel(texel_addr(pool_x[v], pool_y[v]), $urandom);
                    end
                    15, 16, 17: begin
                        if ($urandom_range(0, 1)) begin
                            v = $urandom_range(0, POOL_SIZE - 1);
                            clear_pixel(pool_x[v], pool_y[v]);
                        end else begin
                            pick_pixel(x, y);
                            clear_pixel(x, y);
                        end
                    end
                    18: begin
                        pick_pixel(x, y);
                        pixel_request(OP_UNUSED, x, y);
                    end
                    default: begin
                        pick_pixel(x, y);
                        pixel_request(OP_RASTER, x, y);
                    end
                endcase
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (book.mismatch_count == 0 && book.expected_writes.size() == 0) begin
            $display("triangle_raster_depth_texture_tb passed");
        end else begin
            $display("triangle_raster_depth_texture_tb failed");
        end
        $finish;
    end

    // The depth sweep after reset alone covers all 480000 depth entries.
    initial begin
        #25_000_000;
        $display("triangle_raster_depth_texture_tb failed");
        $finish;
    end

endmodule
